[rtl/nec_ir_pulse_decoder_macros.svh]
// ----------------------------------------------------------------------------
// nec_ir_pulse_decoder_macros.svh
// assertion macros for the nec ir pulse decoder, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef NEC_IR_PULSE_DECODER_MACROS_SVH
`define NEC_IR_PULSE_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication on i_clk, off during reset
`define NEC_IR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nec_ir assertion failed");

// next-cycle implication on i_clk, off during reset
`define NEC_IR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nec_ir assertion failed");

`else

`define NEC_IR_ASSERT_IMP(lbl, ante, cons)
`define NEC_IR_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[rtl/nec_ir_pkg.sv]
// ----------------------------------------------------------------------------
// nec_ir_pkg
// types, register codes and reset values shared by the nec ir decoder
// ----------------------------------------------------------------------------
`default_nettype none

package nec_ir_pkg;

    localparam int CODE_W  = 32;
    localparam int TICK_W  = 8;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_MARK_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_MARK_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_SPACE_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_SPACE_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_SPACE_MAX  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESHOLD  = 3'd7;

    // register reset values in ticks
    localparam logic [CFG_W-1:0] RST_LEAD_MARK_MIN  = 8'd138;
    localparam logic [CFG_W-1:0] RST_LEAD_MARK_MAX  = 8'd152;
    localparam logic [CFG_W-1:0] RST_LEAD_SPACE_MIN = 8'd65;
    localparam logic [CFG_W-1:0] RST_LEAD_SPACE_MAX = 8'd80;
    localparam logic [CFG_W-1:0] RST_BIT_MARK_MIN   = 8'd7;
    localparam logic [CFG_W-1:0] RST_BIT_MARK_MAX   = 8'd11;
    localparam logic [CFG_W-1:0] RST_BIT_SPACE_MAX  = 8'd29;
    localparam logic [CFG_W-1:0] RST_ONE_THRESHOLD  = 8'd16;

    // input action codes
    localparam logic ACT_EDGE     = 1'b0;
    localparam logic ACT_OVERFLOW = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LMARK  = 3'd1,
        PH_LSPACE = 3'd2,
        PH_BMARK  = 3'd3,
        PH_BSPACE = 3'd4
    } t_phase;

    typedef struct packed {
        logic [CFG_W-1:0] lead_mark_min;
        logic [CFG_W-1:0] lead_mark_max;
        logic [CFG_W-1:0] lead_space_min;
        logic [CFG_W-1:0] lead_space_max;
        logic [CFG_W-1:0] bit_mark_min;
        logic [CFG_W-1:0] bit_mark_max;
        logic [CFG_W-1:0] bit_space_max;
        logic [CFG_W-1:0] one_threshold;
    } t_cfg;

    typedef struct packed {
        logic              frame_done;
        logic [CODE_W-1:0] frame_code;
        logic [7:0]        command_byte;
        logic              repeat_seen;
        logic              frame_error;
    } t_result;

    // inclusive window check, empty when lo is above hi
    function automatic logic in_window(input logic [TICK_W-1:0] t,
                                       input logic [CFG_W-1:0] lo,
                                       input logic [CFG_W-1:0] hi);
        return (t >= lo) && (t <= hi);
    endfunction

endpackage

`default_nettype wire

[rtl/nec_ir_core.sv]
// ----------------------------------------------------------------------------
// nec_ir_core
// frame state machine: checks each interval, shifts in bits, forms the result
// ----------------------------------------------------------------------------
`default_nettype none

module nec_ir_core
    import nec_ir_pkg::*;
#(
    parameter int FRAME_BITS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic              i_action,
    input  wire logic [TICK_W-1:0] i_ticks,
    input  wire t_cfg              i_cfg,
    output t_result                o_result
);

    localparam int CNT_W = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(FRAME_BITS - 1);

    t_phase            r_phase, n_phase;
    logic [CNT_W-1:0]  r_bits, n_bits;
    logic [CODE_W-1:0] r_shift, n_shift;

    logic lead_mark_ok, lead_space_ok, bit_mark_ok, bit_space_ok, bit_val, last_bit;

    // interval checks
    always_comb begin
        lead_mark_ok  = in_window(i_ticks, i_cfg.lead_mark_min, i_cfg.lead_mark_max);
        lead_space_ok = in_window(i_ticks, i_cfg.lead_space_min, i_cfg.lead_space_max);
        bit_mark_ok   = in_window(i_ticks, i_cfg.bit_mark_min, i_cfg.bit_mark_max);
        bit_space_ok  = in_window(i_ticks, i_cfg.bit_mark_min, i_cfg.bit_space_max);
        bit_val       = (i_ticks > i_cfg.one_threshold);
        last_bit      = (r_bits == LAST_BIT);
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_action == ACT_OVERFLOW) begin
            n_phase = PH_IDLE;
        end else begin
            unique case (r_phase)
                PH_LMARK:  n_phase = lead_mark_ok ? PH_LSPACE : PH_IDLE;
                PH_LSPACE: n_phase = lead_space_ok ? PH_BMARK : PH_IDLE;
                PH_BMARK:  n_phase = bit_mark_ok ? PH_BSPACE : PH_IDLE;
                PH_BSPACE: n_phase = (bit_space_ok && !last_bit) ? PH_BMARK : PH_IDLE;
                default:   n_phase = PH_LMARK;
            endcase
        end
    end

    // datapath and result flags
    always_comb begin
        n_bits   = r_bits;
        n_shift  = r_shift;
        o_result = '0;
        if (i_action == ACT_EDGE) begin
            unique case (r_phase)
                PH_LMARK: begin
                    o_result.frame_error = !lead_mark_ok;
                end
                PH_LSPACE: begin
                    o_result.repeat_seen = !lead_space_ok;
                end
                PH_BMARK: begin
                    o_result.frame_error = !bit_mark_ok;
                end
                PH_BSPACE: begin
                    if (!bit_space_ok) begin
                        o_result.frame_error = 1'b1;
                    end else begin
                        n_shift = {r_shift[CODE_W-2:0], bit_val};
                        if (last_bit) begin
                            n_bits                = '0;
                            o_result.frame_done   = 1'b1;
                            o_result.frame_code   = n_shift;
                            o_result.command_byte = n_shift[15:8];
                        end else begin
                            n_bits = r_bits + 1'b1;
                        end
                    end
                end
                default: begin
                    // frame start
                    n_bits  = '0;
                    n_shift = '0;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bits  <= '0;
            r_shift <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_bits  <= n_bits;
            r_shift <= n_shift;
        end
    end

endmodule

`default_nettype wire

[rtl/nec_ir_pulse_decoder.sv]
// ----------------------------------------------------------------------------
// nec_ir_pulse_decoder
// nec infrared frame decoder driven by edge events carrying interval ticks
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_axis    in         tuser: action; tdata: elapsed_ticks
//  m_axis    out        tuser: done, repeat, error; tdata: code, command
//  cfg       in         write enable, register index, 8-bit value
//
//  one beat in gives one beat out via input register, decode logic and result
//  register; a new beat can be taken every cycle unless the result side stalls.
//  the frame state register and the window compares form a loop with no other register in it.
//  synchronous active-low reset clears frame state and valids and reloads the window registers.
//  a stalled result holds in the output register while the input register
//  still takes one more beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nec_ir_pulse_decoder_macros.svh"

module nec_ir_pulse_decoder
    import nec_ir_pkg::*;
#(
    parameter int FRAME_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,   // [7:0] elapsed_ticks
    input  wire logic                 s_axis_tuser,   // [0] action

    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [39:0]               m_axis_tdata,   // [31:0] frame_code, [39:32] command_byte
    output logic [2:0]                m_axis_tuser,   // [0] frame_done, [1] repeat_seen, [2] frame_error

    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic              r_in_action;
    logic [TICK_W-1:0] r_in_ticks;
    logic              r_out_valid;
    t_result           r_out;
    t_result           core_result;
    logic              fire;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lead_mark_min  <= RST_LEAD_MARK_MIN;
            r_cfg.lead_mark_max  <= RST_LEAD_MARK_MAX;
            r_cfg.lead_space_min <= RST_LEAD_SPACE_MIN;
            r_cfg.lead_space_max <= RST_LEAD_SPACE_MAX;
            r_cfg.bit_mark_min   <= RST_BIT_MARK_MIN;
            r_cfg.bit_mark_max   <= RST_BIT_MARK_MAX;
            r_cfg.bit_space_max  <= RST_BIT_SPACE_MAX;
            r_cfg.one_threshold  <= RST_ONE_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEAD_MARK_MIN:  r_cfg.lead_mark_min  <= i_cfg_data;
                CFG_LEAD_MARK_MAX:  r_cfg.lead_mark_max  <= i_cfg_data;
                CFG_LEAD_SPACE_MIN: r_cfg.lead_space_min <= i_cfg_data;
                CFG_LEAD_SPACE_MAX: r_cfg.lead_space_max <= i_cfg_data;
                CFG_BIT_MARK_MIN:   r_cfg.bit_mark_min   <= i_cfg_data;
                CFG_BIT_MARK_MAX:   r_cfg.bit_mark_max   <= i_cfg_data;
                CFG_BIT_SPACE_MAX:  r_cfg.bit_space_max  <= i_cfg_data;
                CFG_ONE_THRESHOLD:  r_cfg.one_threshold  <= i_cfg_data;
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    // handshake: decode fires when a beat waits and the result slot frees up
    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_action <= s_axis_tuser;
            r_in_ticks  <= s_axis_tdata;
        end
    end

    // frame decode
    nec_ir_core #(
        .FRAME_BITS (FRAME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_action (r_in_action),
        .i_ticks  (r_in_ticks),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.command_byte, r_out.frame_code};
    assign m_axis_tuser  = {r_out.frame_error, r_out.repeat_seen, r_out.frame_done};

    // checks
    `NEC_IR_ASSERT_IMP(a_one_flag, m_axis_tvalid, $onehot0(m_axis_tuser))
    `NEC_IR_ASSERT_IMP(a_code_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 40'd0)
    `NEC_IR_ASSERT_IMP(a_cmd_byte, m_axis_tvalid, m_axis_tdata[39:32] == m_axis_tdata[15:8])
    `NEC_IR_ASSERT_NXT(a_in_taken, s_axis_tvalid && s_axis_tready, r_in_valid)

endmodule

`default_nettype wire

[verif/nec_ir_pulse_decoder_checker.sv]
// ----------------------------------------------------------------------------
// nec_ir_pulse_decoder_checker
// watches the edge-event and result channels of the nec ir decoder, keeps its
// own copy of the window registers and frame state, predicts one result per
// accepted edge event and compares the result beats in order
// ----------------------------------------------------------------------------
module nec_ir_pulse_decoder_checker
    import nec_ir_pkg::*;
#(
    parameter int FRAME_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_ready,
    input  wire logic [7:0]           i_in_data,    // [7:0] elapsed_ticks
    input  wire logic                 i_in_user,    // [0] action

    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_ready,
    input  wire logic [39:0]          i_out_data,   // [31:0] frame_code, [39:32] command_byte
    input  wire logic [2:0]           i_out_user,   // [0] frame_done, [1] repeat_seen, [2] frame_error

    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,

    output logic [31:0]               o_fail_count,
    output logic [31:0]               o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow of the window registers and the frame state
    t_cfg              win_cfg;
    t_phase            rx_phase;
    logic [5:0]        rx_bits;
    logic [CODE_W-1:0] rx_code;

    // results still owed by the block, oldest first
    t_result           owed_results[$];
    int                fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic logic tick_fits(input logic [7:0] t, input logic [7:0] lo,
                                       input logic [7:0] hi);
        return (t >= lo) && (t <= hi);
    endfunction

    // advance the frame state by one edge event and give its result
    function automatic t_result decode_event(input logic act, input logic [7:0] t);
        t_result r;
        int      next_count;
        r = '0;
        if (act == ACT_OVERFLOW) begin
            rx_phase = PH_IDLE;
        end else begin
            case (rx_phase)
                PH_LMARK: begin
                    if (tick_fits(t, win_cfg.lead_mark_min, win_cfg.lead_mark_max)) begin
                        rx_phase = PH_LSPACE;
                    end else begin
                        r.frame_error = 1'b1;
                        rx_phase = PH_IDLE;
                    end
                end
                PH_LSPACE: begin
                    if (tick_fits(t, win_cfg.lead_space_min, win_cfg.lead_space_max)) begin
                        rx_phase = PH_BMARK;
                    end else begin
                        r.repeat_seen = 1'b1;
                        rx_phase = PH_IDLE;
                    end
                end
                PH_BMARK: begin
                    if (tick_fits(t, win_cfg.bit_mark_min, win_cfg.bit_mark_max)) begin
                        rx_phase = PH_BSPACE;
                    end else begin
                        r.frame_error = 1'b1;
                        rx_phase = PH_IDLE;
                    end
                end
                PH_BSPACE: begin
                    if (!tick_fits(t, win_cfg.bit_mark_min, win_cfg.bit_space_max)) begin
                        r.frame_error = 1'b1;
                        rx_phase = PH_IDLE;
                    end else begin
                        // long space is a one, first bit ends up on top
                        next_count = rx_bits + 1;
                        rx_code = {rx_code[CODE_W-2:0], (t > win_cfg.one_threshold)};
                        if (next_count >= FRAME_BITS) begin
                            r.frame_done   = 1'b1;
                            r.frame_code   = rx_code;
                            r.command_byte = rx_code[15:8];
                            rx_phase = PH_IDLE;
                            rx_bits  = '0;
                        end else begin
                            rx_bits  = next_count[5:0];
                            rx_phase = PH_BMARK;
                        end
                    end
                end
                // idle and unused codes: this edge opens a frame
                default: begin
                    rx_phase = PH_LMARK;
                    rx_bits  = '0;
                    rx_code  = '0;
                end
            endcase
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            win_cfg.lead_mark_min  = RST_LEAD_MARK_MIN;
            win_cfg.lead_mark_max  = RST_LEAD_MARK_MAX;
            win_cfg.lead_space_min = RST_LEAD_SPACE_MIN;
            win_cfg.lead_space_max = RST_LEAD_SPACE_MAX;
            win_cfg.bit_mark_min   = RST_BIT_MARK_MIN;
            win_cfg.bit_mark_max   = RST_BIT_MARK_MAX;
            win_cfg.bit_space_max  = RST_BIT_SPACE_MAX;
            win_cfg.one_threshold  = RST_ONE_THRESHOLD;
            rx_phase = PH_IDLE;
            rx_bits  = '0;
            rx_code  = '0;
            owed_results.delete();
            o_pending_count <= '0;
        end else begin
            // result beat against the oldest owed result
            if (i_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    $error("result beat with no edge event waiting for it");
                    fail_total++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("frame_done", 32'(want.frame_done), 32'(i_out_user[0]));
                    check_field("repeat_seen", 32'(want.repeat_seen), 32'(i_out_user[1]));
                    check_field("frame_error", 32'(want.frame_error), 32'(i_out_user[2]));
                    check_field("frame_code", want.frame_code, i_out_data[31:0]);
                    check_field("command_byte", 32'(want.command_byte),
                                32'(i_out_data[39:32]));
                end
            end

            // edge event beat
            if (i_in_valid && i_in_ready) begin
                owed_results.push_back(decode_event(i_in_user, i_in_data));
            end

            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LEAD_MARK_MIN:  win_cfg.lead_mark_min  = i_cfg_data;
                    CFG_LEAD_MARK_MAX:  win_cfg.lead_mark_max  = i_cfg_data;
                    CFG_LEAD_SPACE_MIN: win_cfg.lead_space_min = i_cfg_data;
                    CFG_LEAD_SPACE_MAX: win_cfg.lead_space_max = i_cfg_data;
                    CFG_BIT_MARK_MIN:   win_cfg.bit_mark_min   = i_cfg_data;
                    CFG_BIT_MARK_MAX:   win_cfg.bit_mark_max   = i_cfg_data;
                    CFG_BIT_SPACE_MAX:  win_cfg.bit_space_max  = i_cfg_data;
                    CFG_ONE_THRESHOLD:  win_cfg.one_threshold  = i_cfg_data;
                    default: ;
                endcase
            end

            o_pending_count <= owed_results.size();
        end
    end

endmodule

[verif/nec_ir_pulse_decoder_test.sv]
// ----------------------------------------------------------------------------
// nec_ir_pulse_decoder_test
// drives edge events into the nec ir decoder: a directed pass over the window
// edges, repeat, error and overflow paths, then random frames, repeats and
// noise under several window settings and handshake idling patterns; the
// checker beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
module nec_ir_pulse_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nec_ir_pkg::*;

    localparam int FRAME_BITS        = 32;
    localparam int FRAME_LEN         = 3 + 2 * FRAME_BITS;
    localparam int RESET_CYCLES      = 10;
    localparam int CYCLE_LIMIT       = 500000;
    localparam int HOLD_CYCLES       = 200;
    localparam int DRAIN_QUIET       = 8;
    localparam int SETTING_COUNT     = 8;
    localparam int BEATS_PER_SETTING = 210;

    logic                 clk;
    logic                 rst_n         = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;   // [7:0] elapsed_ticks
    logic                 s_axis_tuser  = 1'b0; // [0] action

    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [39:0]          m_axis_tdata;         // [31:0] frame_code, [39:32] command_byte
    logic [2:0]           m_axis_tuser;         // [0] frame_done, [1] repeat_seen, [2] frame_error

    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx       = '0;
    logic [CFG_W-1:0]     cfg_data      = '0;

    logic [31:0]          fail_count;
    logic [31:0]          pending_count;

    // stimulus-side copy of the windows, used to shape frames
    t_cfg                 cfg_now;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   beats_sent     = 0;
    int                   cycle_count    = 0;
    int                   stall_left     = 0;
    bit                   hold_req       = 1'b0;
    bit                   hold_taken     = 1'b0;

    nec_ir_pulse_decoder #(
        .FRAME_BITS (FRAME_BITS)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    nec_ir_pulse_decoder_checker #(
        .FRAME_BITS (FRAME_BITS)
    ) decode_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (s_axis_tvalid),
        .i_in_ready      (s_axis_tready),
        .i_in_data       (s_axis_tdata),
        .i_in_user       (s_axis_tuser),
        .i_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .i_out_data      (m_axis_tdata),
        .i_out_user      (m_axis_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    always @(posedge clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (hold_req && !hold_taken) begin
            hold_taken    <= 1'b1;
            stall_left    <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // one edge event beat, with an optional idle gap in front
    task automatic send_beat(input logic act, input logic [7:0] ticks);
        if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ticks;
        s_axis_tuser  <= act;
        do @(posedge clk); while (!s_axis_tready);
        beats_sent++;
    endtask

    // wait until every owed result has come and the block has gone quiet
    task automatic wait_drained();
        int quiet;
        quiet = 0;
        s_axis_tvalid <= 1'b0;
        while (quiet < DRAIN_QUIET) begin
            @(posedge clk);
            quiet = (pending_count == 0) ? quiet + 1 : 0;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic apply_cfg(input t_cfg c);
        cfg_now = c;
        write_reg(CFG_LEAD_MARK_MIN, c.lead_mark_min);
        write_reg(CFG_LEAD_MARK_MAX, c.lead_mark_max);
        write_reg(CFG_LEAD_SPACE_MIN, c.lead_space_min);
        write_reg(CFG_LEAD_SPACE_MAX, c.lead_space_max);
        write_reg(CFG_BIT_MARK_MIN, c.bit_mark_min);
        write_reg(CFG_BIT_MARK_MAX, c.bit_mark_max);
        write_reg(CFG_BIT_SPACE_MAX, c.bit_space_max);
        write_reg(CFG_ONE_THRESHOLD, c.one_threshold);
        cfg_we <= 1'b0;
    endtask

    // random windows with each min at or below its max
    function automatic t_cfg random_cfg();
        t_cfg c;
        c.lead_mark_min  = 8'($urandom_range(255, 0));
        c.lead_mark_max  = 8'($urandom_range(255, c.lead_mark_min));
        c.lead_space_min = 8'($urandom_range(255, 0));
        c.lead_space_max = 8'($urandom_range(255, c.lead_space_min));
        c.bit_mark_min   = 8'($urandom_range(255, 0));
        c.bit_mark_max   = 8'($urandom_range(255, c.bit_mark_min));
        c.bit_space_max  = 8'($urandom_range(255, c.bit_mark_min));
        c.one_threshold  = 8'($urandom_range(255, 0));
        return c;
    endfunction

    function automatic t_cfg setting_cfg(input int which);
        t_cfg c;
        c = random_cfg();
        case (which)
            // reset timing
            0: begin
                c.lead_mark_min  = RST_LEAD_MARK_MIN;
                c.lead_mark_max  = RST_LEAD_MARK_MAX;
                c.lead_space_min = RST_LEAD_SPACE_MIN;
                c.lead_space_max = RST_LEAD_SPACE_MAX;
                c.bit_mark_min   = RST_BIT_MARK_MIN;
                c.bit_mark_max   = RST_BIT_MARK_MAX;
                c.bit_space_max  = RST_BIT_SPACE_MAX;
                c.one_threshold  = RST_ONE_THRESHOLD;
            end
            // widest windows, any nonzero space is a one
            2: begin
                c = '0;
                c.lead_mark_max  = 8'hFF;
                c.lead_space_max = 8'hFF;
                c.bit_mark_max   = 8'hFF;
                c.bit_space_max  = 8'hFF;
            end
            // everything at the top
            3: c = '1;
            // everything at zero
            4: c = '0;
            // empty leader space window: every leader becomes a repeat
            5: begin
                c.lead_space_min = 8'd200;
                c.lead_space_max = 8'd100;
            end
            // empty bit space window: frames die on the first space
            6: begin
                c.bit_mark_min  = 8'd250;
                c.bit_mark_max  = 8'hFF;
                c.bit_space_max = 8'd5;
            end
            default: ;
        endcase
        return c;
    endfunction

    // a tick count in [lo, hi], edges favored; anything when the window is empty
    function automatic logic [7:0] pick_in_window(input int lo, input int hi);
        if (lo > hi) return 8'($urandom_range(255, 0));
        case ($urandom_range(3, 0))
            0: return 8'(lo);
            1: return 8'(hi);
            default: return 8'($urandom_range(hi, lo));
        endcase
    endfunction

    // a tick count outside [lo, hi], often just past an edge
    function automatic logic [7:0] pick_off_window(input int lo, input int hi);
        if (lo > hi) return 8'($urandom_range(255, 0));
        if (lo > 0 && (hi == 255 || $urandom_range(1, 0) == 1)) begin
            return ($urandom_range(1, 0) == 1) ? 8'(lo - 1) : 8'($urandom_range(lo - 1, 0));
        end
        if (hi < 255) begin
            return ($urandom_range(1, 0) == 1) ? 8'(hi + 1) : 8'($urandom_range(255, hi + 1));
        end
        return 8'($urandom_range(255, 0));
    endfunction

    // a valid bit space that decodes to the wanted bit where the windows allow it
    function automatic logic [7:0] pick_bit_space(input logic bit_val);
        int lo, hi, thr, a, b;
        lo  = int'(cfg_now.bit_mark_min);
        hi  = int'(cfg_now.bit_space_max);
        thr = int'(cfg_now.one_threshold);
        if (bit_val) begin
            a = (thr + 1 > lo) ? thr + 1 : lo;
            b = hi;
        end else begin
            a = lo;
            b = (thr < hi) ? thr : hi;
        end
        if (a > b) return pick_in_window(lo, hi);
        return pick_in_window(a, b);
    endfunction

    // window that applies to beat pos of a frame, pos 0 being the opening edge
    function automatic void beat_window(input int pos, output int lo, output int hi);
        if (pos == 1) begin
            lo = int'(cfg_now.lead_mark_min);
            hi = int'(cfg_now.lead_mark_max);
        end else if (pos == 2) begin
            lo = int'(cfg_now.lead_space_min);
            hi = int'(cfg_now.lead_space_max);
        end else if (pos % 2 == 1) begin
            lo = int'(cfg_now.bit_mark_min);
            hi = int'(cfg_now.bit_mark_max);
        end else begin
            lo = int'(cfg_now.bit_mark_min);
            hi = int'(cfg_now.bit_space_max);
        end
    endfunction

    // one frame with a random code; a spoiled frame stops at its bad beat
    task automatic send_frame(input bit spoil);
        logic [31:0] code_bits;
        int          bad_pos;
        int          lo, hi;
        code_bits = $urandom;
        bad_pos   = spoil ? $urandom_range(FRAME_LEN - 1, 1) : FRAME_LEN;
        // at random, an overflow first so the frame starts from idle
        if ($urandom_range(1, 0) == 1) send_beat(ACT_OVERFLOW, 8'($urandom_range(255, 0)));
        send_beat(ACT_EDGE, 8'($urandom_range(255, 0)));
        for (int pos = 1; pos < FRAME_LEN; pos++) begin
            beat_window(pos, lo, hi);
            if (pos == bad_pos) begin
                if ($urandom_range(3, 0) == 0) begin
                    send_beat(ACT_OVERFLOW, 8'($urandom_range(255, 0)));
                end else begin
                    send_beat(ACT_EDGE, pick_off_window(lo, hi));
                end
                return;
            end
            if (pos >= 4 && pos % 2 == 0) begin
                send_beat(ACT_EDGE, pick_bit_space(code_bits[31 - (pos - 4) / 2]));
            end else begin
                send_beat(ACT_EDGE, pick_in_window(lo, hi));
            end
        end
    endtask

    // random mix of frames, repeat leaders and noise
    task automatic run_random(input int quota);
        int stop_at;
        int pick;
        stop_at = beats_sent + quota;
        while (beats_sent < stop_at) begin
            pick = $urandom_range(99, 0);
            if (pick < 60) begin
                send_frame($urandom_range(99, 0) < 25);
            end else if (pick < 75) begin
                // repeat leader: good mark, space out of window
                send_beat(ACT_OVERFLOW, 8'($urandom_range(255, 0)));
                send_beat(ACT_EDGE, 8'($urandom_range(255, 0)));
                send_beat(ACT_EDGE, pick_in_window(int'(cfg_now.lead_mark_min),
                                                   int'(cfg_now.lead_mark_max)));
                send_beat(ACT_EDGE, pick_off_window(int'(cfg_now.lead_space_min),
                                                    int'(cfg_now.lead_space_max)));
            end else begin
                repeat ($urandom_range(6, 1)) begin
                    send_beat(($urandom_range(4, 0) == 0) ? ACT_OVERFLOW : ACT_EDGE,
                              8'($urandom_range(255, 0)));
                end
            end
        end
    endtask

    // window edges and every exit path under the reset timing
    task automatic run_directed();
        // overflow while idle
        send_beat(ACT_OVERFLOW, 8'hFF);
        // leader at its edges, a one and a zero at the limits, then a long bit mark
        send_beat(ACT_EDGE, 8'h00);
        send_beat(ACT_EDGE, RST_LEAD_MARK_MIN);
        send_beat(ACT_EDGE, RST_LEAD_SPACE_MAX);
        send_beat(ACT_EDGE, RST_BIT_MARK_MIN);
        send_beat(ACT_EDGE, RST_BIT_SPACE_MAX);
        send_beat(ACT_EDGE, RST_BIT_MARK_MAX);
        send_beat(ACT_EDGE, RST_ONE_THRESHOLD);
        send_beat(ACT_EDGE, RST_BIT_MARK_MAX + 8'd1);
        // short leader mark
        send_beat(ACT_EDGE, 8'hFF);
        send_beat(ACT_EDGE, RST_LEAD_MARK_MIN - 8'd1);
        // short leader space, taken as repeat
        send_beat(ACT_EDGE, 8'h5A);
        send_beat(ACT_EDGE, RST_LEAD_MARK_MAX);
        send_beat(ACT_EDGE, RST_LEAD_SPACE_MIN - 8'd1);
        // bit space one tick too long
        send_beat(ACT_EDGE, 8'hA5);
        send_beat(ACT_EDGE, RST_LEAD_MARK_MAX);
        send_beat(ACT_EDGE, RST_LEAD_SPACE_MIN);
        send_beat(ACT_EDGE, RST_BIT_MARK_MIN);
        send_beat(ACT_EDGE, RST_BIT_SPACE_MAX + 8'd1);
        // timer overflow in the middle of a frame
        send_beat(ACT_EDGE, 8'h01);
        send_beat(ACT_EDGE, RST_LEAD_MARK_MIN);
        send_beat(ACT_OVERFLOW, 8'h80);
    endtask

    // main sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_cfg(setting_cfg(0));
        run_directed();

        for (int which = 0; which < SETTING_COUNT; which++) begin
            wait_drained();
            apply_cfg(setting_cfg(which));
            case (which % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 84;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 84;
                end
                default: begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 30;
                end
            endcase
            // long result hold-off while the sender keeps pushing
            if (which == 0) hold_req <= 1'b1;
            run_random(BEATS_PER_SETTING);
        end

        wait_drained();
        if (fail_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/nec_ir_pkg.sv
rtl/nec_ir_core.sv
rtl/nec_ir_pulse_decoder.sv
verif/nec_ir_pulse_decoder_checker.sv
verif/nec_ir_pulse_decoder_test.sv
